// ----- sv/affine_grid_point_generator_top_defines.svh -----
// Assertion macros shared by the affine grid point generator RTL
`ifndef AFFINE_GRID_POINT_GENERATOR_TOP_DEFINES_SVH
`define AFFINE_GRID_POINT_GENERATOR_TOP_DEFINES_SVH

// check a property on every clock edge outside reset
`define AGPG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define AGPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/agpg_pkg.sv -----
// Types, constants and codes of the affine grid point generator
package agpg_pkg;

  localparam int unsigned IdxW       = 10;
  localparam int unsigned ExtW       = IdxW + 1;
  localparam int unsigned MagW       = ExtW;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned CoefIdxW   = 4;
  localparam int unsigned CoefCount  = 12;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned CoordFrac  = 14;
  localparam int unsigned OutW       = 20;
  localparam int unsigned AccW       = 36;
  localparam int unsigned MaxExtent  = 1024;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = ExtW;
  localparam int unsigned QueueDepth = 2;

  // radix-16 restoring divider for the normalised coordinate
  localparam int unsigned QuotW      = 16;
  localparam int unsigned DivShift   = CoordFrac + 1;
  localparam int unsigned DivisorW   = ExtW + 1;
  localparam int unsigned DividendW  = ExtW + DivShift + 1;
  localparam int unsigned DivBits    = 4;
  localparam int unsigned DivCycles  = QuotW / DivBits;

  localparam logic signed [CoordW-1:0] CoordOne = CoordW'(1) << CoordFrac;
  localparam int OutMaxI   = (1 << (OutW - 1)) - 1;
  localparam int OutMinI   = -(1 << (OutW - 1));
  localparam int RoundHalf = 1 << (CoordFrac - 1);

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncPoint = 1'b1
  } agpg_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreeD = 3'd0,
    CfgAlign  = 3'd1,
    CfgWidth  = 3'd2,
    CfgHeight = 3'd3,
    CfgDepth  = 3'd4
  } agpg_cfg_e;

  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [MagW-1:0] mag;
    logic [ExtW-1:0] den;
  } agpg_axis_t;

  typedef struct packed {
    logic                    is_load;
    logic [CoefIdxW-1:0]     coef_index;
    logic signed [CoefW-1:0] coef_value;
    logic                    three_d;
    logic                    err;
    agpg_axis_t [2:0]        axis;
  } agpg_entry_t;

endpackage

// ----- sv/agpg_front.sv -----
// Front end: configuration registers, word intake and classification
module agpg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [agpg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [agpg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              func_i,
  input  logic [agpg_pkg::CoefIdxW-1:0]     coef_index_i,
  input  logic signed [agpg_pkg::CoefW-1:0] coef_value_i,
  input  logic [agpg_pkg::IdxW-1:0]         col_index_i,
  input  logic [agpg_pkg::IdxW-1:0]         row_index_i,
  input  logic [agpg_pkg::IdxW-1:0]         slice_index_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output agpg_pkg::agpg_entry_t             q_entry_o
);
  import agpg_pkg::*;

  function automatic logic [ExtW-1:0] clamp_ext(input logic [ExtW-1:0] n);
    if (n == '0) return ExtW'(1);
    if (n > ExtW'(MaxExtent)) return ExtW'(MaxExtent);
    return n;
  endfunction

  function automatic agpg_axis_t build_axis(input logic [IdxW-1:0] idx,
                                            input logic [ExtW-1:0] n,
                                            input logic            align);
    agpg_axis_t      ax;
    logic [ExtW-1:0] odd;
    odd     = ExtW'({idx, 1'b1});
    ax.neg  = odd < n;
    ax.mag  = ax.neg ? (n - odd) : (odd - n);
    ax.den  = align ? (n - ExtW'(1)) : n;
    ax.zero = (n == ExtW'(1));
    return ax;
  endfunction

  logic            three_d_q;
  logic            align_q;
  logic [ExtW-1:0] width_q;
  logic [ExtW-1:0] height_q;
  logic [ExtW-1:0] depth_q;
  logic [ExtW-1:0] w_ext;
  logic [ExtW-1:0] h_ext;
  logic [ExtW-1:0] d_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q <= 1'b0;
      align_q   <= 1'b0;
      width_q   <= ExtW'(1);
      height_q  <= ExtW'(1);
      depth_q   <= ExtW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreeD: three_d_q <= cfg_data_i[0];
        CfgAlign:  align_q   <= cfg_data_i[0];
        CfgWidth:  width_q   <= cfg_data_i;
        CfgHeight: height_q  <= cfg_data_i;
        CfgDepth:  depth_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_ext = clamp_ext(width_q);
  assign h_ext = clamp_ext(height_q);
  assign d_ext = clamp_ext(depth_q);

  always_comb begin
    q_entry_o            = '0;
    q_entry_o.is_load    = (func_i == FuncLoad);
    q_entry_o.coef_index = coef_index_i;
    q_entry_o.coef_value = coef_value_i;
    q_entry_o.three_d    = three_d_q;
    q_entry_o.err        = (ExtW'(col_index_i) >= w_ext) || (ExtW'(row_index_i) >= h_ext) ||
                           (three_d_q && (ExtW'(slice_index_i) >= d_ext));
    q_entry_o.axis[0]    = build_axis(col_index_i, w_ext, align_q);
    q_entry_o.axis[1]    = build_axis(row_index_i, h_ext, align_q);
    q_entry_o.axis[2]    = build_axis(slice_index_i, d_ext, align_q);
    if (!three_d_q) begin
      q_entry_o.axis[2].zero = 1'b1;
    end
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

endmodule

// ----- sv/agpg_fifo.sv -----
// Short word queue between the front end and the back end
`include "affine_grid_point_generator_top_defines.svh"
module agpg_fifo #(
  parameter int unsigned DEPTH = agpg_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  agpg_pkg::agpg_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output agpg_pkg::agpg_entry_t entry_o,
  output logic                  empty_o
);
  import agpg_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  agpg_entry_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `AGPG_ASSERT(a_fifo_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(DEPTH), "queue count overflow")

endmodule

// ----- sv/agpg_div.sv -----
// Radix-16 restoring divider for one normalised coordinate
module agpg_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [agpg_pkg::DividendW-1:0]     dividend_i,
  input  logic [agpg_pkg::DivisorW-1:0]      divisor_i,
  output logic                               done_o,
  output logic [agpg_pkg::QuotW-1:0]         quot_o
);
  import agpg_pkg::*;

  localparam int unsigned CntW = $clog2(DivCycles);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivisorW-1:0] rem_d;
  logic [QuotW-1:0]    low_q;
  logic [QuotW-1:0]    low_d;
  logic [DivisorW-1:0] div_q;

  always_comb begin
    logic [DivisorW:0] trial;
    trial = '0;
    rem_d = rem_q;
    low_d = low_q;
    for (int s = 0; s < DivBits; s++) begin
      trial = {rem_d, low_d[QuotW-1]};
      low_d = {low_d[QuotW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        low_d[0] = 1'b1;
      end
      rem_d = trial[DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DivisorW'(dividend_i[DividendW-1:QuotW]);
      low_q <= dividend_i[QuotW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

// ----- sv/agpg_back.sv -----
// Back end: coefficient store, coordinate division, multiply-accumulate and result word
`include "affine_grid_point_generator_top_defines.svh"
module agpg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  agpg_pkg::agpg_entry_t              q_entry_i,
  output logic                               q_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic signed [agpg_pkg::OutW-1:0]   out_x_o,
  output logic signed [agpg_pkg::OutW-1:0]   out_y_o,
  output logic signed [agpg_pkg::OutW-1:0]   out_z_o,
  output logic                               index_error_o,
  output logic                               saturated_o
);
  import agpg_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StMac  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;
  localparam int unsigned Lanes = 3;
  localparam logic [1:0] TermLast2d = 2'd2;
  localparam logic [1:0] TermLast3d = 2'd3;
  localparam logic signed [AccW-1:0] AccMax  = AccW'(OutMaxI);
  localparam logic signed [AccW-1:0] AccMin  = AccW'(OutMinI);
  localparam logic signed [AccW-1:0] AccHalf = AccW'(RoundHalf);

  logic [1:0]                     state_q;
  logic [1:0]                     state_d;
  logic signed [CoefW-1:0]        store_q [CoefCount];
  logic                           three_d_q;
  logic                           err_q;
  logic [1:0]                     term_q;
  logic signed [CoordW-1:0]       coord_q [Lanes];
  logic signed [AccW-1:0]         acc_q [Lanes];
  logic                           out_valid_q;
  logic [Lanes-1:0]               neg_q;
  logic [Lanes-1:0]               zero_q;

  logic                           div_start;
  logic [DividendW-1:0]           dividend [Lanes];
  logic [DivisorW-1:0]            divisor [Lanes];
  logic [Lanes-1:0]               div_done;
  logic                           done_all;
  logic [QuotW-1:0]               div_quot [Lanes];
  logic signed [CoordW-1:0]       coord_sel;
  logic signed [CoefW-1:0]        coef_sel [Lanes];
  logic signed [CoefW+CoordW-1:0] prod [Lanes];
  logic signed [AccW-1:0]         rnd [Lanes];
  logic signed [OutW-1:0]         clip [Lanes];
  logic [Lanes-1:0]               lane_sat;
  logic                           term_last;
  logic                           res_we;

  assign q_pop_o   = (state_q == StIdle) && !q_empty_i;
  assign div_start = q_pop_o && !q_entry_i.is_load && !q_entry_i.err;
  assign done_all  = &div_done;
  assign term_last = (term_q == (three_d_q ? TermLast3d : TermLast2d));
  assign res_we    = (state_q == StFin) && (!out_valid_q || pop_i);

  for (genvar a = 0; a < Lanes; a++) begin : g_lane
    assign dividend[a] = (DividendW'(q_entry_i.axis[a].mag) << DivShift) +
                         DividendW'(q_entry_i.axis[a].den);
    assign divisor[a]  = {q_entry_i.axis[a].den, 1'b0};

    agpg_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (dividend[a]),
      .divisor_i  (divisor[a]),
      .done_o     (div_done[a]),
      .quot_o     (div_quot[a])
    );
  end

  always_comb begin
    case (term_q)
      2'd0: begin
        coord_sel   = coord_q[0];
        coef_sel[0] = store_q[0];
        coef_sel[1] = three_d_q ? store_q[4] : store_q[3];
        coef_sel[2] = store_q[8];
      end
      2'd1: begin
        coord_sel   = coord_q[1];
        coef_sel[0] = store_q[1];
        coef_sel[1] = three_d_q ? store_q[5] : store_q[4];
        coef_sel[2] = store_q[9];
      end
      2'd2: begin
        coord_sel   = three_d_q ? coord_q[2] : CoordOne;
        coef_sel[0] = store_q[2];
        coef_sel[1] = three_d_q ? store_q[6] : store_q[5];
        coef_sel[2] = store_q[10];
      end
      default: begin
        coord_sel   = CoordOne;
        coef_sel[0] = store_q[3];
        coef_sel[1] = store_q[7];
        coef_sel[2] = store_q[11];
      end
    endcase
    for (int a = 0; a < Lanes; a++) begin
      prod[a] = coef_sel[a] * coord_sel;
      rnd[a]  = (acc_q[a] + AccHalf) >>> CoordFrac;
      if (rnd[a] > AccMax) begin
        clip[a]     = OutW'(OutMaxI);
        lane_sat[a] = 1'b1;
      end else if (rnd[a] < AccMin) begin
        clip[a]     = OutW'(OutMinI);
        lane_sat[a] = 1'b1;
      end else begin
        clip[a]     = rnd[a][OutW-1:0];
        lane_sat[a] = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_pop_o && !q_entry_i.is_load) begin
          state_d = q_entry_i.err ? StFin : StDiv;
        end
      end
      StDiv: begin
        if (done_all) begin
          state_d = StMac;
        end
      end
      StMac: begin
        if (term_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (res_we) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      for (int e = 0; e < CoefCount; e++) begin
        store_q[e] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o && q_entry_i.is_load && (q_entry_i.coef_index < CoefIdxW'(CoefCount))) begin
        store_q[q_entry_i.coef_index] <= q_entry_i.coef_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      three_d_q <= q_entry_i.three_d;
      err_q     <= q_entry_i.err;
    end
    if ((state_q == StDiv) && done_all) begin
      term_q <= '0;
      for (int a = 0; a < Lanes; a++) begin
        acc_q[a] <= '0;
        if (zero_q[a]) begin
          coord_q[a] <= '0;
        end else if (neg_q[a]) begin
          coord_q[a] <= -CoordW'(div_quot[a]);
        end else begin
          coord_q[a] <= CoordW'(div_quot[a]);
        end
      end
    end else if (state_q == StMac) begin
      term_q <= term_q + 2'd1;
      for (int a = 0; a < Lanes; a++) begin
        acc_q[a] <= acc_q[a] + AccW'(prod[a]);
      end
    end
    if (res_we) begin
      if (err_q) begin
        out_x_o     <= '0;
        out_y_o     <= '0;
        out_z_o     <= '0;
        saturated_o <= 1'b0;
      end else begin
        out_x_o     <= clip[0];
        out_y_o     <= clip[1];
        out_z_o     <= three_d_q ? clip[2] : '0;
        saturated_o <= lane_sat[0] || lane_sat[1] || (three_d_q && lane_sat[2]);
      end
      index_error_o <= err_q;
    end
  end

  // hold sign and extent-of-one flags of each axis while the dividers run
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      for (int a = 0; a < Lanes; a++) begin
        neg_q[a]  <= q_entry_i.axis[a].neg;
        zero_q[a] <= q_entry_i.axis[a].zero;
      end
    end
  end

  assign empty_o = !out_valid_q;

  `AGPG_ASSERT(a_div_done_in_div, clk_i, rst_ni, !done_all || (state_q == StDiv), "divider finished outside the divide step")
  `AGPG_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni, q_pop_o && q_entry_i.is_load, state_q == StIdle, "load word left the idle state")
  `AGPG_ASSERT(a_term_bound, clk_i, rst_ni, (state_q != StMac) || !three_d_q || (term_q <= TermLast3d), "term count out of range")
  `AGPG_ASSERT(a_term_bound_2d, clk_i, rst_ni, (state_q != StMac) || three_d_q || (term_q <= TermLast2d), "term count out of range in 2D")

endmodule

// ----- sv/affine_grid_point_generator_top.sv -----
// Top level of the affine grid point generator
//
//   channel   direction  handshake          words
//   point in  in         push_i / full_o    coefficient load or grid point
//   result    out        empty_o / pop_i    transformed coordinate, flags
//   config    in         cfg_we_i           register write, no wait
//
// A load word is taken by the back end without leaving the idle state; a grid point runs
// through the radix-16 coordinate dividers and then one multiply-accumulate per lane for
// each coefficient term. A point with an index error skips both and goes to the result.
// Reset clears the coefficient store and the control registers at once. The front end
// takes words into the queue until it is full while a result waits to be popped.
module affine_grid_point_generator_top #(
  parameter int unsigned QUEUE_DEPTH = agpg_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [agpg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [agpg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              func_i,
  input  logic [agpg_pkg::CoefIdxW-1:0]     coef_index_i,
  input  logic signed [agpg_pkg::CoefW-1:0] coef_value_i,
  input  logic [agpg_pkg::IdxW-1:0]         col_index_i,
  input  logic [agpg_pkg::IdxW-1:0]         row_index_i,
  input  logic [agpg_pkg::IdxW-1:0]         slice_index_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [agpg_pkg::OutW-1:0]  out_x_o,
  output logic signed [agpg_pkg::OutW-1:0]  out_y_o,
  output logic signed [agpg_pkg::OutW-1:0]  out_z_o,
  output logic                              index_error_o,
  output logic                              saturated_o
);
  import agpg_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_empty;
  logic        q_pop;
  agpg_entry_t q_wr_entry;
  agpg_entry_t q_rd_entry;

  agpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .func_i        (func_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .col_index_i   (col_index_i),
    .row_index_i   (row_index_i),
    .slice_index_i (slice_index_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wr_entry)
  );

  agpg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  agpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .index_error_o (index_error_o),
    .saturated_o   (saturated_o)
  );

endmodule
